// File: hdl/cds_pkg.sv
`default_nettype none

package cds_pkg;

	// Field widths of the request and response beats.
	localparam int unsigned DAY_W  = 5;
	localparam int unsigned MON_W  = 4;
	localparam int unsigned YEAR_W = 12;
	localparam int unsigned AMT_W  = 16;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned DN_W   = 17;
	localparam int unsigned STAT_W = 2;

	// Internal year counter: wide enough for any year reached inside the span.
	localparam int unsigned YC_W   = 13;
	localparam int unsigned Y400_W = 9;
	localparam int unsigned YLEN_W = 9;
	localparam int unsigned MLEN_W = 5;

	localparam int unsigned DEF_BASE_YEAR = 1900;
	localparam int unsigned DEF_YEAR_SPAN = 256;

	localparam int unsigned DAYS_COMMON_YEAR = 365;
	localparam int unsigned DAYS_LEAP_YEAR   = 366;
	localparam int unsigned DAYS_PER_WEEK    = 7;
	localparam int unsigned GREG_CYCLE       = 400;
	localparam int unsigned CENTURY          = 100;

	// Period kinds.
	localparam logic [KIND_W-1:0] PK_DAYS    = 2'd0;
	localparam logic [KIND_W-1:0] PK_WEEKS   = 2'd1;
	localparam logic [KIND_W-1:0] PK_YEARS   = 2'd2;
	localparam logic [KIND_W-1:0] PK_INVALID = 2'd3;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_PERIOD = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE      = 2'd2;

	typedef struct packed {
		logic [DAY_W-1:0]  start_day;
		logic [MON_W-1:0]  start_month;
		logic [YEAR_W-1:0] start_year;
		logic              go_back;
		logic [AMT_W-1:0]  amount;
		logic [KIND_W-1:0] period_kind;
	} cds_req_t;

	typedef struct packed {
		logic [DAY_W-1:0]  new_day;
		logic [MON_W-1:0]  new_month;
		logic [YEAR_W-1:0] new_year;
		logic [DN_W-1:0]   new_day_number;
		logic [STAT_W-1:0] status;
	} cds_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DN_YEAR,
		S_DN_MOD,
		S_DN_MON,
		S_SHIFT,
		S_CHECK,
		S_TD_YEAR,
		S_TD_MON,
		S_YSHIFT,
		S_FIN
	} cds_state_t;

	// Which conversion pass the controller is in.
	typedef enum logic [1:0] {
		P_START,
		P_YEAR,
		P_SECOND,
		P_FINAL
	} cds_pass_t;

	typedef struct packed {
		logic              load;
		logic              dn_year_step;
		logic              md_load;
		logic              md_step;
		logic              md_done;
		logic              mon_add;
		logic              day_add;
		logic              shift;
		logic              td_init;
		logic              td_year_step;
		logic              mon_init;
		logic              mon_sub;
		logic              yshift;
		logic              out_wr;
		logic [STAT_W-1:0] out_stat;
	} cds_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              year_lt;
		logic              md_ge;
		logic              mon_lt;
		logic              acc_pos;
		logic              acc_over;
		logic              acc_gt_ylen;
		logic              acc_gt_mlen;
		logic              ny_ok;
		logic              out_free;
	} cds_sts_t;

	// Leap rule from the year modulo 400.
	function automatic logic leap_of(input logic [Y400_W-1:0] y);
		return (y[1:0] == 2'b00) && (y != Y400_W'(CENTURY)) &&
			(y != Y400_W'(2 * CENTURY)) && (y != Y400_W'(3 * CENTURY));
	endfunction

	function automatic logic [YLEN_W-1:0] year_len(input logic leap);
		return leap ? YLEN_W'(DAYS_LEAP_YEAR) : YLEN_W'(DAYS_COMMON_YEAR);
	endfunction

	// Month numbers above twelve count as 31-day months.
	function automatic logic [MLEN_W-1:0] month_len(input logic [MON_W-1:0] m,
		input logic leap);
		logic [MLEN_W-1:0] len;
		case (m)
			4'd2: begin
				len = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// File: hdl/cds_if.sv
`default_nettype none

interface cds_req_if;
	import cds_pkg::*;
	logic     valid;
	logic     ready;
	cds_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cds_rsp_if;
	import cds_pkg::*;
	logic     valid;
	logic     ready;
	cds_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/cds_ctrl.sv
`default_nettype none

module cds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cds_pkg::cds_sts_t sts,
	output cds_pkg::cds_cmd_t cmd
);
	import cds_pkg::*;

	cds_state_t        state_q, state_d;
	cds_pass_t         pass_q, pass_d;
	logic [STAT_W-1:0] stat_q, stat_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= P_START;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
			stat_q  <= stat_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		stat_d  = stat_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DN_YEAR;
					pass_d  = P_START;
				end
			end
			S_DN_YEAR: begin
				if (!sts.year_lt) begin
					state_d = S_DN_MOD;
				end
			end
			S_DN_MOD: begin
				if (!sts.md_ge) begin
					state_d = S_DN_MON;
				end
			end
			S_DN_MON: begin
				if (!sts.mon_lt) begin
					state_d = (pass_q == P_START) ? S_SHIFT : S_CHECK;
				end
			end
			S_SHIFT: begin
				case (sts.kind)
					PK_DAYS, PK_WEEKS: begin
						state_d = S_CHECK;
					end
					PK_YEARS: begin
						if (sts.acc_pos) begin
							state_d = S_TD_YEAR;
							pass_d  = P_YEAR;
						end else begin
							state_d = S_FIN;
							stat_d  = ST_RANGE;
						end
					end
					PK_INVALID: begin
						state_d = S_FIN;
						stat_d  = ST_BAD_PERIOD;
					end
					default: begin
						state_d = S_FIN;
						stat_d  = ST_BAD_PERIOD;
					end
				endcase
			end
			S_CHECK: begin
				if (sts.acc_pos && !sts.acc_over) begin
					state_d = S_TD_YEAR;
					pass_d  = P_FINAL;
				end else begin
					state_d = S_FIN;
					stat_d  = ST_RANGE;
				end
			end
			S_TD_YEAR: begin
				if (!sts.acc_gt_ylen) begin
					state_d = S_TD_MON;
				end
			end
			S_TD_MON: begin
				if (!sts.acc_gt_mlen) begin
					if (pass_q == P_YEAR) begin
						state_d = S_YSHIFT;
					end else begin
						state_d = S_FIN;
						stat_d  = ST_OK;
					end
				end
			end
			S_YSHIFT: begin
				if (sts.ny_ok) begin
					state_d = S_DN_YEAR;
					pass_d  = P_SECOND;
				end else begin
					state_d = S_FIN;
					stat_d  = ST_RANGE;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DN_YEAR: begin
				cmd.dn_year_step = sts.year_lt;
				cmd.md_load      = !sts.year_lt;
			end
			S_DN_MOD: begin
				cmd.md_step = sts.md_ge;
				cmd.md_done = !sts.md_ge;
			end
			S_DN_MON: begin
				cmd.mon_add = sts.mon_lt;
				cmd.day_add = !sts.mon_lt;
			end
			S_SHIFT: begin
				cmd.shift   = (sts.kind == PK_DAYS) || (sts.kind == PK_WEEKS);
				cmd.td_init = (sts.kind == PK_YEARS) && sts.acc_pos;
			end
			S_CHECK: begin
				cmd.td_init = sts.acc_pos && !sts.acc_over;
			end
			S_TD_YEAR: begin
				cmd.td_year_step = sts.acc_gt_ylen;
				cmd.mon_init     = !sts.acc_gt_ylen;
			end
			S_TD_MON: begin
				cmd.mon_sub = sts.acc_gt_mlen;
			end
			S_YSHIFT: begin
				cmd.yshift = sts.ny_ok;
			end
			S_FIN: begin
				cmd.out_wr   = sts.out_free;
				cmd.out_stat = stat_q;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DN_YEAR))
		else $error("accepted beat did not start the date conversion");

	a_write_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_wr |-> sts.out_free)
		else $error("result written while the output register is full");

	a_ok_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && stat_q == ST_OK) |-> (pass_q == P_FINAL))
		else $error("ok result finished before the final conversion pass");

endmodule

`default_nettype wire

// File: hdl/cds_dpath.sv
`default_nettype none

module cds_dpath #(
	parameter int unsigned BASE_YEAR = cds_pkg::DEF_BASE_YEAR,
	parameter int unsigned YEAR_SPAN = cds_pkg::DEF_YEAR_SPAN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cds_pkg::cds_req_t req_data,
	input  cds_pkg::cds_cmd_t cmd,
	output cds_pkg::cds_sts_t sts,
	cds_rsp_if.source         rsp
);
	import cds_pkg::*;

	// The accumulator must hold the largest start day number plus a week shift,
	// the last day of the span, and a negative result of a backward shift.
	localparam int unsigned ACC_W = $clog2((2**YEAR_W - BASE_YEAR + 2) * DAYS_LEAP_YEAR +
		YEAR_SPAN * DAYS_LEAP_YEAR + DAYS_PER_WEEK * 2**AMT_W) + 1;
	localparam int unsigned DLT_W = AMT_W + 3;
	localparam int unsigned NY_W  = ((YC_W > AMT_W) ? YC_W : AMT_W) + 2;
	localparam int LAST_YR = BASE_YEAR + YEAR_SPAN - 1;
	localparam int PRE_YR  = BASE_YEAR - 1;
	localparam int LAST_DN = DAYS_COMMON_YEAR * YEAR_SPAN +
		(LAST_YR / 4 - LAST_YR / 100 + LAST_YR / 400) -
		(PRE_YR / 4 - PRE_YR / 100 + PRE_YR / 400);
	localparam logic [Y400_W-1:0] BASE_MOD = Y400_W'(BASE_YEAR % GREG_CYCLE);

	logic [DAY_W-1:0]  tday_q;
	logic [MON_W-1:0]  tmon_q;
	logic [YC_W-1:0]   ty_q;
	logic              back_q;
	logic [AMT_W-1:0]  amt_q;
	logic [KIND_W-1:0] kind_q;
	logic [DLT_W-1:0]  delta_q;
	logic [ACC_W-1:0]  acc_q;
	logic [YC_W-1:0]   yy_q;
	logic [Y400_W-1:0] y400_q;
	logic [YC_W-1:0]   md_q;
	logic [MON_W-1:0]  mon_q;
	logic [DN_W-1:0]   res_q;
	cds_rsp_t          rsp_q;
	logic              rsp_vld_q;

	logic              leap;
	logic [YLEN_W-1:0] ylen;
	logic [MLEN_W-1:0] mlen;
	logic [Y400_W-1:0] y400_nxt;
	logic [DLT_W-1:0]  wk;
	logic [NY_W-1:0]   ny;

	assign leap     = leap_of(y400_q);
	assign ylen     = year_len(leap);
	assign mlen     = month_len(mon_q, leap);
	assign y400_nxt = (y400_q == Y400_W'(GREG_CYCLE - 1)) ? '0 : y400_q + 1'b1;
	assign wk       = {req_data.amount, 3'b000} - DLT_W'(req_data.amount);
	assign ny       = back_q ? (NY_W'(yy_q) - NY_W'(amt_q)) : (NY_W'(yy_q) + NY_W'(amt_q));

	always_comb begin
		sts.kind        = kind_q;
		sts.year_lt     = yy_q < ty_q;
		sts.md_ge       = md_q >= YC_W'(GREG_CYCLE);
		sts.mon_lt      = mon_q < tmon_q;
		sts.acc_pos     = !acc_q[ACC_W-1] && (acc_q != '0);
		sts.acc_over    = !acc_q[ACC_W-1] && (acc_q > ACC_W'(LAST_DN));
		sts.acc_gt_ylen = !acc_q[ACC_W-1] && (acc_q > ACC_W'(ylen));
		sts.acc_gt_mlen = !acc_q[ACC_W-1] && (acc_q > ACC_W'(mlen));
		sts.ny_ok       = !ny[NY_W-1] && (ny >= NY_W'(BASE_YEAR)) &&
			(ny < NY_W'(BASE_YEAR + YEAR_SPAN));
		sts.out_free    = !rsp_vld_q || rsp.ready;
	end

	// One command at a time walks the shared accumulator.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tday_q  <= req_data.start_day;
			tmon_q  <= req_data.start_month;
			ty_q    <= YC_W'(req_data.start_year);
			back_q  <= req_data.go_back;
			amt_q   <= req_data.amount;
			kind_q  <= req_data.period_kind;
			delta_q <= (req_data.period_kind == PK_WEEKS) ? wk : DLT_W'(req_data.amount);
			acc_q   <= '0;
			yy_q    <= YC_W'(BASE_YEAR);
			y400_q  <= BASE_MOD;
		end else if (cmd.dn_year_step) begin
			acc_q  <= acc_q + ACC_W'(ylen);
			yy_q   <= yy_q + 1'b1;
			y400_q <= y400_nxt;
		end else if (cmd.md_load) begin
			md_q <= ty_q;
		end else if (cmd.md_step) begin
			md_q <= md_q - YC_W'(GREG_CYCLE);
		end else if (cmd.md_done) begin
			y400_q <= md_q[Y400_W-1:0];
			mon_q  <= MON_W'(1);
		end else if (cmd.mon_add) begin
			acc_q <= acc_q + ACC_W'(mlen);
			mon_q <= mon_q + 1'b1;
		end else if (cmd.day_add) begin
			acc_q <= acc_q + ACC_W'(tday_q);
		end else if (cmd.shift) begin
			acc_q <= back_q ? (acc_q - ACC_W'(delta_q)) : (acc_q + ACC_W'(delta_q));
		end else if (cmd.td_init) begin
			res_q  <= acc_q[DN_W-1:0];
			yy_q   <= YC_W'(BASE_YEAR);
			y400_q <= BASE_MOD;
		end else if (cmd.td_year_step) begin
			acc_q  <= acc_q - ACC_W'(ylen);
			yy_q   <= yy_q + 1'b1;
			y400_q <= y400_nxt;
		end else if (cmd.mon_init) begin
			mon_q <= MON_W'(1);
		end else if (cmd.mon_sub) begin
			acc_q <= acc_q - ACC_W'(mlen);
			mon_q <= mon_q + 1'b1;
		end else if (cmd.yshift) begin
			ty_q   <= ny[YC_W-1:0];
			tday_q <= acc_q[DAY_W-1:0];
			tmon_q <= mon_q;
			acc_q  <= '0;
			yy_q   <= YC_W'(BASE_YEAR);
			y400_q <= BASE_MOD;
		end
	end

	// Result register; a failed status clears every date field.
	always_ff @(posedge clk) begin
		if (cmd.out_wr) begin
			if (cmd.out_stat == ST_OK) begin
				rsp_q.new_day        <= acc_q[DAY_W-1:0];
				rsp_q.new_month      <= mon_q;
				rsp_q.new_year       <= yy_q[YEAR_W-1:0];
				rsp_q.new_day_number <= res_q;
			end else begin
				rsp_q.new_day        <= '0;
				rsp_q.new_month      <= '0;
				rsp_q.new_year       <= '0;
				rsp_q.new_day_number <= '0;
			end
			rsp_q.status <= cmd.out_stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (cmd.out_wr) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	a_fail_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_q.status != ST_OK) |->
		(rsp_q.new_day == '0 && rsp_q.new_month == '0 && rsp_q.new_year == '0 &&
		rsp_q.new_day_number == '0))
		else $error("failed result carries a nonzero date field");

	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_vld_q && rsp_q.status == ST_OK) |->
		(rsp_q.new_day != '0 && rsp_q.new_month != '0 &&
		rsp_q.new_month <= MON_W'(12)))
		else $error("ok result is not a normalized date");

	a_write_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_wr |=> rsp_vld_q)
		else $error("written result not presented");

endmodule

`default_nettype wire

// File: hdl/calendar_date_shift_top.sv
// Steps (days or weeks): a year walk up to the start year, a modulo-400 reduction,
//   a month walk and the day add build the start day number in the single day
//   accumulator, then the shift, a range check and a year and month walk back to
//   a date; years add a start-date walk and a shifted-date conversion of that form.
// Flow: a beat is taken once the last is done, even while its result still waits.
// Reset: arst_n clears the controller and the result valid flag; no clearing pass.
`default_nettype none

module calendar_date_shift_top #(
	parameter int unsigned BASE_YEAR = cds_pkg::DEF_BASE_YEAR,
	parameter int unsigned YEAR_SPAN = cds_pkg::DEF_YEAR_SPAN
) (
	input  logic      clk,
	input  logic      arst_n,
	cds_req_if.sink   req,
	cds_rsp_if.source rsp
);
	import cds_pkg::*;

	// The controller sequences the walks; the datapath owns the accumulator,
	// the year, month and modulo-400 counters, and the result register.
	cds_cmd_t cmd;
	cds_sts_t sts;
	logic     in_ready;

	// A request beat is taken only in the idle state, and the result register
	// sits between the controller and the response channel, so a new beat can
	// start while the previous result still waits to be taken.
	assign req.ready = in_ready;

	cds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Day numbers count 1 January of BASE_YEAR as day 1; results beyond the
	// last day of BASE_YEAR + YEAR_SPAN - 1 report a range status.
	cds_dpath #(
		.BASE_YEAR (BASE_YEAR),
		.YEAR_SPAN (YEAR_SPAN)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// File: dv/calendar_date_shift_checker.sv
`timescale 1ns / 1ps

module calendar_date_shift_checker
	import cds_pkg::*;
#(
	parameter int unsigned BASE_YEAR = DEF_BASE_YEAR,
	parameter int unsigned YEAR_SPAN = DEF_YEAR_SPAN
) (
	input  logic clk,
	input  logic arst_n,
	cds_req_if   req,
	cds_rsp_if   rsp,
	output int   fail_count,
	output int   outstanding,
	output int   ok_seen,
	output int   range_seen,
	output int   bad_period_seen
);

	// Signed copies so that year arithmetic below the base year stays signed.
	localparam longint BASE = longint'(BASE_YEAR);
	localparam longint SPAN = longint'(YEAR_SPAN);

	cds_rsp_t expected_dates[$];
	cds_rsp_t want;
	cds_rsp_t got;
	int       failures;
	int       n_ok;
	int       n_range;
	int       n_bad_period;

	function automatic bit is_leap_year(input longint y);
		return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
	endfunction

	function automatic longint days_in_year(input longint y);
		return is_leap_year(y) ? 366 : 365;
	endfunction

	// Month numbers outside 1..12 fall through to 31 days.
	function automatic longint days_in_month(input longint m, input longint y);
		if (m == 2)
			return is_leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic longint leap_years_through(input longint n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	function automatic longint days_before(input longint y);
		if (y <= BASE)
			return 0;
		return 365 * (y - BASE) + leap_years_through(y - 1) - leap_years_through(BASE - 1);
	endfunction

	function automatic longint date_to_number(input longint d, input longint m,
		input longint y);
		longint n;
		n = days_before(y);
		for (longint k = 1; k < m; k++)
			n += days_in_month(k, y);
		return n + d;
	endfunction

	// Only called with a day number of one or more.
	function automatic void number_to_date(input longint dn, output longint d,
		output longint m, output longint y);
		longint rest;
		rest = dn;
		y = BASE;
		m = 1;
		while (rest > days_in_year(y)) begin
			rest -= days_in_year(y);
			y++;
		end
		while (rest > days_in_month(m, y)) begin
			rest -= days_in_month(m, y);
			m++;
		end
		d = rest;
	endfunction

	function automatic cds_rsp_t shift_date(input cds_req_t r);
		longint            start_dn;
		longint            moved;
		longint            last_dn;
		longint            amt;
		longint            target_year;
		longint            d;
		longint            m;
		longint            y;
		logic [STAT_W-1:0] st;
		cds_rsp_t          e;
		amt = longint'(r.amount);
		last_dn = days_before(BASE + SPAN);
		start_dn = date_to_number(longint'(r.start_day), longint'(r.start_month),
			longint'(r.start_year));
		moved = 0;
		st = ST_OK;
		d = 0;
		m = 0;
		y = 0;
		case (r.period_kind)
			PK_DAYS: begin
				moved = r.go_back ? start_dn - amt : start_dn + amt;
			end
			PK_WEEKS: begin
				moved = r.go_back ? start_dn - amt * 7 : start_dn + amt * 7;
			end
			PK_YEARS: begin
				if (start_dn < 1) begin
					st = ST_RANGE;
				end else begin
					number_to_date(start_dn, d, m, y);
					target_year = r.go_back ? y - amt : y + amt;
					if (target_year < BASE || target_year >= BASE + SPAN)
						st = ST_RANGE;
					else
						moved = date_to_number(d, m, target_year);
				end
			end
			default: begin
				st = ST_BAD_PERIOD;
			end
		endcase
		if (st == ST_OK && (moved < 1 || moved > last_dn))
			st = ST_RANGE;
		if (st == ST_OK) begin
			number_to_date(moved, d, m, y);
		end else begin
			d = 0;
			m = 0;
			y = 0;
			moved = 0;
		end
		e.new_day = DAY_W'(d);
		e.new_month = MON_W'(m);
		e.new_year = YEAR_W'(y);
		e.new_day_number = DN_W'(moved);
		e.status = st;
		return e;
	endfunction

	function automatic int field_differs(input string name, input longint exp_val,
		input longint act_val);
		if (exp_val == act_val)
			return 0;
		$error("%s: expected %0d, got %0d", name, exp_val, act_val);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_dates.delete();
			failures = 0;
			n_ok = 0;
			n_range = 0;
			n_bad_period = 0;
			fail_count <= 0;
			outstanding <= 0;
			ok_seen <= 0;
			range_seen <= 0;
			bad_period_seen <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (expected_dates.size() == 0) begin
					$error("result beat with no request pending (status %0d)", got.status);
					failures++;
				end else begin
					want = expected_dates.pop_front();
					failures += field_differs("new_day", longint'(want.new_day),
						longint'(got.new_day));
					failures += field_differs("new_month", longint'(want.new_month),
						longint'(got.new_month));
					failures += field_differs("new_year", longint'(want.new_year),
						longint'(got.new_year));
					failures += field_differs("new_day_number",
						longint'(want.new_day_number), longint'(got.new_day_number));
					failures += field_differs("status", longint'(want.status),
						longint'(got.status));
				end
				case (got.status)
					ST_OK: begin
						n_ok++;
					end
					ST_RANGE: begin
						n_range++;
					end
					ST_BAD_PERIOD: begin
						n_bad_period++;
					end
					default: begin
					end
				endcase
			end
			if (req.valid && req.ready)
				expected_dates.push_back(shift_date(req.data));
			fail_count <= failures;
			outstanding <= expected_dates.size();
			ok_seen <= n_ok;
			range_seen <= n_range;
			bad_period_seen <= n_bad_period;
		end
	end

endmodule

// File: dv/calendar_date_shift_top_test.sv
`timescale 1ns / 1ps

module calendar_date_shift_top_test;
	import cds_pkg::*;

	localparam int unsigned BASE_YEAR = DEF_BASE_YEAR;
	localparam int unsigned YEAR_SPAN = DEF_YEAR_SPAN;
	localparam int unsigned LAST_YEAR = BASE_YEAR + YEAR_SPAN - 1;
	localparam int unsigned TOP_YEAR  = (1 << YEAR_W) - 1;
	localparam int unsigned TOP_AMT   = (1 << AMT_W) - 1;
	localparam int          RANDOM_BEATS = 1000;
	// A slow beat walks a few thousand years; this window outlasts one such walk.
	localparam int          DRAIN_CYCLES = 8000;
	// The slowest plausible run stays well inside this limit, with a wide margin.
	localparam longint      CYCLE_LIMIT  = 4_000_000;

	logic   clk;
	logic   arst_n;
	// While set, neither the sender nor the receiver inserts idle cycles.
	bit     quiet_phase;
	longint cycles = 0;
	int     sent = 0;
	int     fail_count;
	int     outstanding;
	int     ok_seen;
	int     range_seen;
	int     bad_period_seen;

	cds_req_if req_ch ();
	cds_rsp_if rsp_ch ();

	calendar_date_shift_top #(
		.BASE_YEAR(BASE_YEAR),
		.YEAR_SPAN(YEAR_SPAN)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// The checker watches both channels, predicts each result and keeps the score.
	calendar_date_shift_checker #(
		.BASE_YEAR(BASE_YEAR),
		.YEAR_SPAN(YEAR_SPAN)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.fail_count     (fail_count),
		.outstanding    (outstanding),
		.ok_seen        (ok_seen),
		.range_seen     (range_seen),
		.bad_period_seen(bad_period_seen)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still pending.",
				cycles, outstanding);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic cds_req_t make_req(input int d, input int m, input int y,
		input bit back, input int amt, input logic [KIND_W-1:0] kind);
		cds_req_t r;
		r.start_day = DAY_W'(d);
		r.start_month = MON_W'(m);
		r.start_year = YEAR_W'(y);
		r.go_back = back;
		r.amount = AMT_W'(amt);
		r.period_kind = kind;
		return r;
	endfunction

	// Holds valid high until the beat is taken. A zero gap keeps valid high across
	// back-to-back beats, so valid never drops and rises within one time step.
	task automatic send_beat(input cds_req_t beat);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= beat;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	// Result side: for every beat draw a random stall (none in a quiet phase), then accept.
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = quiet_phase ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	initial begin
		cds_req_t beat;
		int       pick;
		int       amt_cap;
		arst_n = 1'b0;
		quiet_phase = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the ends of the span, leap-day handling, unchecked start
		// fields and every period kind.
		// First day of the span, and one day before it.
		send_beat(make_req(1, 1, BASE_YEAR, 1'b0, 0, PK_DAYS));
		send_beat(make_req(1, 1, BASE_YEAR, 1'b1, 1, PK_DAYS));
		// Last day of the span, one day past it, and the largest day amount back from the end and forward from the start.
		send_beat(make_req(31, 12, LAST_YEAR, 1'b0, 0, PK_DAYS));
		send_beat(make_req(31, 12, LAST_YEAR, 1'b0, 1, PK_DAYS));
		send_beat(make_req(31, 12, LAST_YEAR, 1'b1, TOP_AMT, PK_DAYS));
		send_beat(make_req(1, 1, BASE_YEAR, 1'b0, TOP_AMT, PK_DAYS));
		// Weeks: the largest amount overshoots, a smaller one lands near the end, and 52 go back from mid-2000.
		send_beat(make_req(1, 1, BASE_YEAR, 1'b0, TOP_AMT, PK_WEEKS));
		send_beat(make_req(1, 1, BASE_YEAR, 1'b0, 13357, PK_WEEKS));
		send_beat(make_req(15, 6, 2000, 1'b1, 52, PK_WEEKS));
		// Years: a leap day landing in a common year rolls into March; one landing in a leap year stays.
		send_beat(make_req(29, 2, 2000, 1'b0, 1, PK_YEARS));
		send_beat(make_req(29, 2, 2004, 1'b1, 4, PK_YEARS));
		// Years: the full span forward, one past it, and all the way back.
		send_beat(make_req(1, 1, BASE_YEAR, 1'b0, YEAR_SPAN - 1, PK_YEARS));
		send_beat(make_req(1, 1, BASE_YEAR, 1'b0, YEAR_SPAN, PK_YEARS));
		send_beat(make_req(31, 12, LAST_YEAR, 1'b1, YEAR_SPAN - 1, PK_YEARS));
		// A start date of day zero with day number zero yields no date to shift.
		send_beat(make_req(0, 0, BASE_YEAR, 1'b0, 3, PK_YEARS));
		send_beat(make_req(0, 1, 0, 1'b0, 5, PK_YEARS));
		// Start days past the end of their month, and months above twelve.
		send_beat(make_req(29, 2, 1900, 1'b0, 0, PK_YEARS));
		send_beat(make_req(29, 2, 2100, 1'b0, 0, PK_DAYS));
		send_beat(make_req(31, 4, 2023, 1'b0, 0, PK_DAYS));
		send_beat(make_req(31, 15, 2000, 1'b0, 0, PK_DAYS));
		// Start years before the base count no whole years.
		send_beat(make_req(5, 3, BASE_YEAR - 1, 1'b0, 10, PK_DAYS));
		// A start far past the span shifted back into it.
		send_beat(make_req(31, 15, TOP_YEAR, 1'b1, 2000, PK_YEARS));
		// An invalid period with every input bit set.
		send_beat(make_req(31, 15, TOP_YEAR, 1'b1, TOP_AMT, PK_INVALID));

		// Random part: mostly real dates inside the span with capped amounts, plus a
		// share of odd start fields and overshooting amounts.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			// Every 64 beats, decide whether this stretch runs without idling.
			if (i % 64 == 0)
				quiet_phase = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			beat.period_kind = (pick < 35) ? PK_DAYS : (pick < 60) ? PK_WEEKS :
				(pick < 94) ? PK_YEARS : PK_INVALID;
			beat.go_back = 1'($urandom_range(0, 1));
			// Years far beyond the span are slow, so they stay rare.
			case ($urandom_range(0, 19))
				0: begin
					beat.start_year = YEAR_W'($urandom_range(0, BASE_YEAR - 1));
				end
				1: begin
					beat.start_year = YEAR_W'($urandom_range(LAST_YEAR + 1, TOP_YEAR));
				end
				default: begin
					beat.start_year = YEAR_W'($urandom_range(BASE_YEAR, LAST_YEAR));
				end
			endcase
			case ($urandom_range(0, 14))
				0: begin
					beat.start_month = MON_W'($urandom_range(0, (1 << MON_W) - 1));
				end
				default: begin
					beat.start_month = MON_W'($urandom_range(1, 12));
				end
			endcase
			case ($urandom_range(0, 9))
				0: begin
					beat.start_day = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
				end
				1: begin
					beat.start_day = DAY_W'($urandom_range(29, 31));
				end
				default: begin
					beat.start_day = DAY_W'($urandom_range(1, 28));
				end
			endcase
			case (beat.period_kind)
				PK_DAYS: begin
					amt_cap = 40000;
				end
				PK_WEEKS: begin
					amt_cap = 6000;
				end
				PK_YEARS: begin
					amt_cap = 200;
				end
				default: begin
					amt_cap = TOP_AMT;
				end
			endcase
			case ($urandom_range(0, 9))
				0: begin
					beat.amount = AMT_W'($urandom_range(0, TOP_AMT));
				end
				1: begin
					beat.amount = AMT_W'($urandom_range(0, 3));
				end
				default: begin
					beat.amount = AMT_W'($urandom_range(0, amt_cap));
				end
			endcase
			send_beat(beat);
		end
		req_ch.valid <= 1'b0;
		quiet_phase = 1'b1;

		// Let the checker's pending count catch up with the last accepted beat.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		// Any stray extra result beat would show up within this window.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d request beats across days, weeks, years and invalid periods.",
			sent);
		$display("Results: %0d dates in range, %0d out of range, %0d with a bad period.",
			ok_seen, range_seen, bad_period_seen);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/cds_pkg.sv
hdl/cds_if.sv
hdl/cds_ctrl.sv
hdl/cds_dpath.sv
hdl/calendar_date_shift_top.sv
dv/calendar_date_shift_checker.sv
dv/calendar_date_shift_top_test.sv
